FILE: sv/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg - sliding window median filter package
// Shared defaults, register reset value and the cell control struct.
// ----------------------------------------------------------------------------
package swmf_pkg;

	// default geometry
	localparam int WINDOW_MAX_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	// window size register
	localparam int          CFG_BITS    = 6;
	localparam logic [5:0]  WINDOW_RST  = 6'd3;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic age;      // age all entries, drop those leaving the window
		logic compact;  // shift entries left over the first hole
		logic insert;   // insert the new sample at its sorted place
		logic clear;    // empty the window
	} swmf_ctl_t;

endpackage

FILE: sv/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell - one position of the sorted window
// Holds one entry (value, age, valid) and trades it with its neighbors.
// ----------------------------------------------------------------------------
module swmf_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_BITS    = 5,
	parameter int CNT_BITS    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swmf_pkg::swmf_ctl_t           ctl,
	input  logic [CNT_BITS-1:0]           win,
	input  logic signed [SAMPLE_BITS-1:0] new_sample,
	// lower neighbor
	input  logic                          left_valid,
	input  logic                          left_gt,
	input  logic                          left_hole,
	input  logic signed [SAMPLE_BITS-1:0] left_value,
	input  logic [AGE_BITS-1:0]           left_age,
	// upper neighbor
	input  logic                          right_valid,
	input  logic signed [SAMPLE_BITS-1:0] right_value,
	input  logic [AGE_BITS-1:0]           right_age,
	// own state
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic [AGE_BITS-1:0]           age,
	output logic                          gt,
	output logic                          hole_out,
	output logic                          misplaced
);
	import swmf_pkg::*;

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [AGE_BITS-1:0]           age_q;
	logic [CNT_BITS-1:0]           age_inc;
	logic                          drop;
	logic                          take_left;
	logic                          take_new;

	// neighbor-facing flags
	assign age_inc   = CNT_BITS'(age_q) + CNT_BITS'(1);
	assign drop      = age_inc >= win;
	assign gt        = valid_q && (value_q > new_sample);
	assign hole_out  = left_hole | ~valid_q;
	assign misplaced = valid_q & left_hole;

	// insertion: larger entries move up, new sample lands at the first slot
	// that is empty or holds a larger value
	assign take_left = left_gt;
	assign take_new  = !left_gt && left_valid && (!valid_q || gt);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.age) begin
			if (valid_q && drop) begin
				valid_q <= 1'b0;
			end
		end else if (ctl.compact) begin
			if (hole_out) begin
				valid_q <= right_valid;
			end
		end else if (ctl.insert) begin
			if (take_left || take_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.age) begin
			age_q <= AGE_BITS'(age_inc);
		end else if (ctl.compact) begin
			if (hole_out) begin
				value_q <= right_value;
				age_q   <= right_age;
			end
		end else if (ctl.insert) begin
			if (take_left) begin
				value_q <= left_value;
				age_q   <= left_age;
			end else if (take_new) begin
				value_q <= new_sample;
				age_q   <= '0;
			end
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

FILE: sv/sliding_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_top - running median over a sample stream
// Sequence per sample: age on acceptance, a compaction step for each entry
// dropped from inside the sorted chain, insert, then the result register loads.
// in_stall holds off the next sample until that sequence is through; the result
// step waits while a held result is stalled by out_stall.
// Reset: window empty, window_size = 3, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_top #(
	parameter int WINDOW_MAX  = swmf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [swmf_pkg::CFG_BITS-1:0] cfg_wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS:0]   median_x2,
	output logic                          last_result
);
	import swmf_pkg::*;

	localparam int AGE_BITS = $clog2(WINDOW_MAX);
	localparam int NUM_BITS = $clog2(WINDOW_MAX + 1);
	localparam int CW       = (NUM_BITS > CFG_BITS) ? NUM_BITS : CFG_BITS;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_COMPACT = 2'd1;
	localparam logic [1:0] ST_RESULT  = 2'd2;

	logic [1:0]                    state_q;
	logic [CFG_BITS-1:0]           window_size_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS:0]   med_q;
	logic                          last_res_q;

	logic [CW-1:0]                 ws_ext;
	logic [CW-1:0]                 w_eff;
	logic [CW-1:0]                 idx_a;
	logic [CW-1:0]                 idx_b;
	swmf_ctl_t                     ctl;
	logic                          accept;
	logic                          out_free;
	logic                          need_compact;
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] med_a;
	logic signed [SAMPLE_BITS-1:0] med_b;

	// chain wiring
	logic                          cell_valid [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
	logic [AGE_BITS-1:0]           cell_age   [WINDOW_MAX];
	logic                          cell_gt    [WINDOW_MAX];
	logic                          cell_hole  [WINDOW_MAX];
	logic                          cell_misp  [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]         valid_vec;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RST;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
		end
	end

	// effective window: zero means one, saturate at capacity
	assign ws_ext = CW'(window_size_q);
	always_comb begin
		priority if (ws_ext == '0) begin
			w_eff = CW'(1);
		end else if (ws_ext > CW'(WINDOW_MAX)) begin
			w_eff = CW'(WINDOW_MAX);
		end else begin
			w_eff = ws_ext;
		end
	end
	assign idx_a = w_eff >> 1;
	assign idx_b = w_eff[0] ? idx_a : (idx_a - CW'(1));

	// handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// cell commands
	always_comb begin
		ctl         = '0;
		ctl.age     = accept;
		ctl.compact = (state_q == ST_COMPACT) && need_compact;
		ctl.insert  = (state_q == ST_COMPACT) && !need_compact;
		ctl.clear   = (state_q == ST_RESULT) && out_free && last_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_COMPACT;
					end
				end
				ST_COMPACT: begin
					if (!need_compact) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample;
			last_q <= last_sample;
		end
	end

	// row of cells
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                          l_valid;
		logic                          l_gt;
		logic                          l_hole;
		logic signed [SAMPLE_BITS-1:0] l_value;
		logic [AGE_BITS-1:0]           l_age;
		logic                          r_valid;
		logic signed [SAMPLE_BITS-1:0] r_value;
		logic [AGE_BITS-1:0]           r_age;

		if (i == 0) begin : g_head
			assign l_valid = 1'b1;
			assign l_gt    = 1'b0;
			assign l_hole  = 1'b0;
			assign l_value = '0;
			assign l_age   = '0;
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_gt    = cell_gt[i-1];
			assign l_hole  = cell_hole[i-1];
			assign l_value = cell_value[i-1];
			assign l_age   = cell_age[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_value = '0;
			assign r_age   = '0;
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
			assign r_age   = cell_age[i+1];
		end

		swmf_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_BITS    (AGE_BITS),
			.CNT_BITS    (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.win         (w_eff),
			.new_sample  (x_q),
			.left_valid  (l_valid),
			.left_gt     (l_gt),
			.left_hole   (l_hole),
			.left_value  (l_value),
			.left_age    (l_age),
			.right_valid (r_valid),
			.right_value (r_value),
			.right_age   (r_age),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.age         (cell_age[i]),
			.gt          (cell_gt[i]),
			.hole_out    (cell_hole[i]),
			.misplaced   (cell_misp[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	// window status and middle entries (AND-OR select over the row)
	always_comb begin
		need_compact = 1'b0;
		full         = 1'b0;
		med_a        = '0;
		med_b        = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			need_compact = need_compact | cell_misp[i];
			full  = full | (cell_valid[i] && (CW'(i) == (w_eff - CW'(1))));
			med_a = med_a | (cell_value[i] & {SAMPLE_BITS{CW'(i) == idx_a}});
			med_b = med_b | (cell_value[i] & {SAMPLE_BITS{CW'(i) == idx_b}});
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= full;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			med_q      <= {med_a[SAMPLE_BITS-1], med_a} + {med_b[SAMPLE_BITS-1], med_b};
			last_res_q <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign median_x2   = med_q;
	assign last_result = last_res_q;

`ifndef SYNTHESIS
	// entries are packed from the bottom whenever the block is idle
	a_packed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("window entries not packed while idle");

	// the end of a sequence leaves an empty window
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && out_free && last_q) |=> (valid_vec == '0))
		else $error("window not empty after last sample");

	// insertion always finds a free slot inside the window
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |-> ($countones(valid_vec) < int'(w_eff)))
		else $error("no room for the new sample");

	// a result only appears out of the result step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESULT))
		else $error("result raised outside the result step");
`endif

endmodule
